// ----- rtl/vtll_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the vector to latitude/longitude converter.
// Used by vtll_cordic and vector_to_latitude_longitude; depends on nothing.
package vtll_pkg;

	// Datapath width of the CORDIC x/y registers (scaled components, 55 bits plus growth).
	localparam int CW    = 60;
	// Angle accumulator width, radians in Q30 (covers the sum of all arctangents).
	localparam int AW    = 34;
	localparam int STEPS = 30;
	// Fraction bits of the internal angle.
	localparam int QA    = 30;
	// Width of the result angle fields.
	localparam int OW    = 25;

	localparam logic signed [AW-1:0] PI_Q30      = 34'sd3373259426;
	localparam logic signed [AW-1:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic [29:0]          INV_GAIN    = 30'd652032874;
	localparam logic signed [31:0]   DEG_Q24     = 32'sd961263669;

	// Configuration register addresses (word index).
	localparam logic ADDR_ANGLE_CFG = 1'b0;

	typedef logic signed [CW-1:0] vec_t;
	typedef logic signed [AW-1:0] ang_t;

	// Arctangent of 2^-i in Q30.
	function automatic ang_t atan_q30(input int i);
		ang_t r;
		r = '0;
		unique case (i)
			0:  r = 34'sd843314857;
			1:  r = 34'sd497837829;
			2:  r = 34'sd263043837;
			3:  r = 34'sd133525159;
			4:  r = 34'sd67021687;
			5:  r = 34'sd33543516;
			6:  r = 34'sd16775851;
			7:  r = 34'sd8388437;
			8:  r = 34'sd4194283;
			9:  r = 34'sd2097149;
			default: r = ang_t'(34'sd1 <<< (QA - i));
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/vtll_cordic.sv -----
`timescale 1ns / 1ps
// Pipelined vectoring CORDIC: one register stage for the quarter-turn
// pre-rotation and one per micro-rotation. Depends on vtll_pkg.
module vtll_cordic #(
	parameter int SIDE_W = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  vtll_pkg::vec_t in_a,
	input  vtll_pkg::vec_t in_b,
	input  logic [SIDE_W-1:0] in_side,
	output logic           out_valid,
	output vtll_pkg::vec_t out_mag,
	output vtll_pkg::ang_t out_ang,
	output logic [SIDE_W-1:0] out_side
);
	import vtll_pkg::*;

	logic              v_s    [0:STEPS];
	vec_t              a_s    [0:STEPS];
	vec_t              b_s    [0:STEPS];
	ang_t              ang_s  [0:STEPS];
	logic [SIDE_W-1:0] side_s [0:STEPS];

	// Pre-rotation by a quarter turn when the first operand is negative.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		side_s[0] <= in_side;
		if (in_a[CW-1]) begin
			if (!in_b[CW-1]) begin
				a_s[0]   <= in_b;
				b_s[0]   <= -in_a;
				ang_s[0] <= HALF_PI_Q30;
			end else begin
				a_s[0]   <= -in_b;
				b_s[0]   <= in_a;
				ang_s[0] <= -HALF_PI_Q30;
			end
		end else begin
			a_s[0]   <= in_a;
			b_s[0]   <= in_b;
			ang_s[0] <= '0;
		end
	end

	// One micro-rotation per stage, driving b toward zero.
	for (genvar i = 0; i < STEPS; i++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			side_s[i+1] <= side_s[i];
			if (!b_s[i][CW-1]) begin
				a_s[i+1]   <= a_s[i] + (b_s[i] >>> i);
				b_s[i+1]   <= b_s[i] - (a_s[i] >>> i);
				ang_s[i+1] <= ang_s[i] + atan_q30(i);
			end else begin
				a_s[i+1]   <= a_s[i] - (b_s[i] >>> i);
				b_s[i+1]   <= b_s[i] + (a_s[i] >>> i);
				ang_s[i+1] <= ang_s[i] - atan_q30(i);
			end
		end
	end

	assign out_valid = v_s[STEPS];
	assign out_mag   = a_s[STEPS];
	assign out_ang   = ang_s[STEPS];
	assign out_side  = side_s[STEPS];

endmodule

// ----- rtl/vector_to_latitude_longitude.sv -----
`timescale 1ns / 1ps
// The done strobe follows each start beat through the pipeline; one input beat per cycle.
// The path is input scaling, a 31-stage CORDIC for longitude and magnitude, two stages
// of gain correction, a 31-stage CORDIC for latitude and two stages of unit conversion.
// busy is always low. arst_n clears all valid bits and selects radians.
// Depends on vtll_pkg and vtll_cordic.
module vector_to_latitude_longitude #(
	parameter int COMPONENT_BITS  = 16,
	parameter int ANGLE_FRAC_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [COMPONENT_BITS-1:0] vec_x,
	input  logic signed [COMPONENT_BITS-1:0] vec_y,
	input  logic signed [COMPONENT_BITS-1:0] vec_z,
	output logic                      done,
	output logic signed [vtll_pkg::OW-1:0] latitude,
	output logic signed [vtll_pkg::OW-1:0] longitude,
	output logic                      zero_vector,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [2:0]                paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);
	import vtll_pkg::*;

	localparam int SHIFT   = 56 - COMPONENT_BITS;
	localparam int EXT     = CW - COMPONENT_BITS;
	localparam int PW      = AW + 32;
	localparam int DEG_SH  = 54 - ANGLE_FRAC_BITS;
	localparam int RAD_SH  = 30 - ANGLE_FRAC_BITS;
	localparam int LATENCY = 2 * (STEPS + 1) + 5;
	localparam int SIDE1_W = 3 + CW;
	localparam int SIDE2_W = 3 + AW;

	localparam logic signed [PW-1:0] DEG_RND = PW'(1) <<< (DEG_SH - 1);
	localparam logic signed [AW-1:0] RAD_RND = AW'(1) <<< (RAD_SH - 1);

	// Configuration register.
	logic deg_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_q <= 1'b0;
		end else if (psel && penable && pwrite && (paddr[2] == ADDR_ANGLE_CFG)) begin
			deg_q <= pwdata[0];
		end
	end

	assign prdata = (paddr[2] == ADDR_ANGLE_CFG) ? {31'd0, deg_q} : 32'd0;
	assign busy   = 1'b0;

	// Stage 1: scale components to the common 2^55 range and flag special cases.
	logic v_s1;
	vec_t x_s1, y_s1, z_s1;
	logic zero_s1, pole_s1, ypos_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		x_s1    <= vec_t'({{EXT{vec_x[COMPONENT_BITS-1]}}, vec_x}) <<< SHIFT;
		y_s1    <= vec_t'({{EXT{vec_y[COMPONENT_BITS-1]}}, vec_y}) <<< SHIFT;
		z_s1    <= vec_t'({{EXT{vec_z[COMPONENT_BITS-1]}}, vec_z}) <<< SHIFT;
		pole_s1 <= (vec_x == '0) && (vec_z == '0);
		zero_s1 <= (vec_x == '0) && (vec_y == '0) && (vec_z == '0);
		ypos_s1 <= !vec_y[COMPONENT_BITS-1] && (vec_y != '0);
	end

	// Longitude CORDIC on (z, x); y rides along for the second pass.
	logic              c1_v;
	vec_t              c1_mag;
	ang_t              c1_ang;
	logic [SIDE1_W-1:0] c1_side;

	vtll_cordic #(.SIDE_W(SIDE1_W)) u_cordic_lon (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_a      (z_s1),
		.in_b      (x_s1),
		.in_side   ({zero_s1, pole_s1, ypos_s1, y_s1}),
		.out_valid (c1_v),
		.out_mag   (c1_mag),
		.out_ang   (c1_ang),
		.out_side  (c1_side)
	);

	// Stage 2: gain correction partial products (magnitude is never negative).
	logic        v_s2;
	logic [59:0] hi_s2, lo_s2;
	ang_t        lon_s2;
	logic [2:0]  flg_s2;
	vec_t        y_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= c1_v;
		end
	end

	always_ff @(posedge clk) begin
		hi_s2  <= c1_mag[CW-1:QA] * INV_GAIN;
		lo_s2  <= c1_mag[QA-1:0] * INV_GAIN;
		lon_s2 <= c1_ang;
		flg_s2 <= c1_side[SIDE1_W-1:CW];
		y_s2   <= c1_side[CW-1:0];
	end

	// Stage 3: combine the partial products into the corrected magnitude.
	logic       v_s3;
	vec_t       r_s3;
	ang_t       lon_s3;
	logic [2:0] flg_s3;
	vec_t       y_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		r_s3   <= vec_t'(hi_s2 + (lo_s2 >> QA));
		lon_s3 <= lon_s2;
		flg_s3 <= flg_s2;
		y_s3   <= y_s2;
	end

	// Latitude CORDIC on (magnitude, y).
	logic              c2_v;
	vec_t              c2_mag;
	ang_t              c2_ang;
	logic [SIDE2_W-1:0] c2_side;

	vtll_cordic #(.SIDE_W(SIDE2_W)) u_cordic_lat (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_a      (r_s3),
		.in_b      (y_s3),
		.in_side   ({flg_s3, lon_s3}),
		.out_valid (c2_v),
		.out_mag   (c2_mag),
		.out_ang   (c2_ang),
		.out_side  (c2_side)
	);

	// Stage 4: saturate, apply pole and zero cases, multiply for degrees.
	logic c2_zero, c2_pole, c2_ypos;
	ang_t c2_lon, lat_sel, lon_sel;

	assign {c2_zero, c2_pole, c2_ypos} = c2_side[SIDE2_W-1:AW];
	assign c2_lon = c2_side[AW-1:0];

	always_comb begin
		priority if (c2_zero) begin
			lat_sel = '0;
			lon_sel = '0;
		end else if (c2_pole) begin
			lat_sel = c2_ypos ? HALF_PI_Q30 : -HALF_PI_Q30;
			lon_sel = '0;
		end else begin
			lat_sel = (c2_ang > HALF_PI_Q30) ? HALF_PI_Q30 :
				((c2_ang < -HALF_PI_Q30) ? -HALF_PI_Q30 : c2_ang);
			lon_sel = (c2_lon > PI_Q30) ? PI_Q30 :
				((c2_lon < -PI_Q30) ? -PI_Q30 : c2_lon);
		end
	end

	logic                 v_s4, zero_s4;
	ang_t                 lat_s4, lon_s4;
	logic signed [PW-1:0] latd_s4, lond_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= c2_v;
		end
	end

	always_ff @(posedge clk) begin
		zero_s4 <= c2_zero;
		lat_s4  <= lat_sel;
		lon_s4  <= lon_sel;
		latd_s4 <= PW'(lat_sel) * PW'(DEG_Q24);
		lond_s4 <= PW'(lon_sel) * PW'(DEG_Q24);
	end

	// Stage 5: round to the output fraction and register the result beat.
	logic                 v_s5, zero_s5;
	logic signed [OW-1:0] lat_s5, lon_s5;
	logic signed [PW-1:0] latd_r, lond_r;
	ang_t                 latr_r, lonr_r;

	assign latd_r = (latd_s4 + DEG_RND) >>> DEG_SH;
	assign lond_r = (lond_s4 + DEG_RND) >>> DEG_SH;
	assign latr_r = (lat_s4 + RAD_RND) >>> RAD_SH;
	assign lonr_r = (lon_s4 + RAD_RND) >>> RAD_SH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		zero_s5 <= zero_s4;
		lat_s5  <= deg_q ? latd_r[OW-1:0] : latr_r[OW-1:0];
		lon_s5  <= deg_q ? lond_r[OW-1:0] : lonr_r[OW-1:0];
	end

	assign done        = v_s5;
	assign latitude    = lat_s5;
	assign longitude   = lon_s5;
	assign zero_vector = zero_s5;

	// Every result beat traces back to a start beat a fixed latency earlier.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("result beat without matching start beat");

	// A zero vector yields zero angles.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && zero_vector) |-> (latitude == '0 && longitude == '0))
		else $error("zero vector produced nonzero angle");

	// The two CORDIC passes stay in lockstep with the stage valids.
	a_align: assert property (@(posedge clk) disable iff (!arst_n)
		c2_v |-> $past(c1_v, STEPS + 3))
		else $error("latitude pass out of step with longitude pass");

endmodule

// ----- test/vtll_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for vector_to_latitude_longitude: watches the command, result and register ports,
// predicts latitude and longitude with its own CORDIC model and compares every result beat.
// Depends on vtll_pkg for widths and constants.
module vtll_checker #(
	parameter int COMPONENT_BITS  = 16,
	parameter int ANGLE_FRAC_BITS = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	input  logic                                    busy,
	input  logic signed [COMPONENT_BITS-1:0]        vec_x,
	input  logic signed [COMPONENT_BITS-1:0]        vec_y,
	input  logic signed [COMPONENT_BITS-1:0]        vec_z,
	input  logic                                    done,
	input  logic signed [vtll_pkg::OW-1:0]          latitude,
	input  logic signed [vtll_pkg::OW-1:0]          longitude,
	input  logic                                    zero_vector,
	input  logic                                    psel,
	input  logic                                    penable,
	input  logic                                    pwrite,
	input  logic [2:0]                              paddr,
	input  logic [31:0]                             pwdata,
	input  logic                                    pready,
	output int                                      mismatches,
	output int                                      outstanding
);
	import vtll_pkg::*;

	typedef struct packed {
		logic signed [OW-1:0] lat;
		logic signed [OW-1:0] lon;
		logic                 zero_vec;
	} angles_t;

	localparam logic [2:0] ANGLE_CFG_BYTE_ADDR = {ADDR_ANGLE_CFG, 2'b00};
	localparam int NUM_ROT = 30;
	localparam longint ARCTAN_Q30 [NUM_ROT] = '{
		843314857, 497837829, 263043837, 133525159, 67021687,
		33543516, 16775851, 8388437, 4194283, 2097149,
		1048576, 524288, 262144, 131072, 65536,
		32768, 16384, 8192, 4096, 2048,
		1024, 512, 256, 128, 64,
		32, 16, 8, 4, 2
	};

	angles_t angles_pending[$];
	logic    degrees_mode;

	assign outstanding = angles_pending.size();

	// Vectoring rotation: returns atan2(b, a) in Q30 and leaves the scaled magnitude in mag.
	function automatic longint vector_angle(input longint a_in, input longint b_in,
			output longint mag);
		longint a, b, ang, t, da, db;
		a = a_in;
		b = b_in;
		ang = 0;
		if (a < 0) begin
			t = a;
			if (b >= 0) begin
				a = b;
				b = -t;
				ang = longint'(HALF_PI_Q30);
			end else begin
				a = -b;
				b = t;
				ang = -longint'(HALF_PI_Q30);
			end
		end
		for (int i = 0; i < NUM_ROT; i++) begin
			da = b >>> i;
			db = a >>> i;
			if (b >= 0) begin
				a += da;
				b -= db;
				ang += ARCTAN_Q30[i];
			end else begin
				a -= da;
				b += db;
				ang -= ARCTAN_Q30[i];
			end
		end
		mag = a;
		return ang;
	endfunction

	function automatic longint saturate(input longint v, input longint lim);
		return (v > lim) ? lim : ((v < -lim) ? -lim : v);
	endfunction

	// Rounds a Q30 radian angle to the output format, in radians or degrees.
	function automatic logic signed [OW-1:0] to_units(input longint a, input logic deg);
		longint r;
		if (deg)
			r = (a * longint'(DEG_Q24) + (longint'(1) <<< (53 - ANGLE_FRAC_BITS)))
				>>> (54 - ANGLE_FRAC_BITS);
		else
			r = (a + (longint'(1) <<< (29 - ANGLE_FRAC_BITS))) >>> (30 - ANGLE_FRAC_BITS);
		return r[OW-1:0];
	endfunction

	function automatic angles_t predict_angles(input logic signed [COMPONENT_BITS-1:0] vx,
			input logic signed [COMPONENT_BITS-1:0] vy,
			input logic signed [COMPONENT_BITS-1:0] vz, input logic deg);
		angles_t res;
		longint scale, x, y, z, lat, lon, mag, r, unused_mag;
		scale = longint'(1) <<< (56 - COMPONENT_BITS);
		x = longint'(vx) * scale;
		y = longint'(vy) * scale;
		z = longint'(vz) * scale;
		res = '0;
		if (x == 0 && y == 0 && z == 0) begin
			res.zero_vec = 1'b1;
			return res;
		end
		// On the polar axis the longitude is defined as zero.
		if (x == 0 && z == 0) begin
			lat = (y > 0) ? longint'(HALF_PI_Q30) : -longint'(HALF_PI_Q30);
			lon = 0;
		end else begin
			lon = saturate(vector_angle(z, x, mag), longint'(PI_Q30));
			r = (mag >>> 30) * longint'(INV_GAIN)
				+ (((mag & ((longint'(1) <<< 30) - 1)) * longint'(INV_GAIN)) >>> 30);
			lat = saturate(vector_angle(r, y, unused_mag), longint'(HALF_PI_Q30));
		end
		res.lat = to_units(lat, deg);
		res.lon = to_units(lon, deg);
		return res;
	endfunction

	// Track the unit register, queue predictions on command beats, check result beats.
	always @(posedge clk or negedge arst_n) begin
		angles_t exp_a;
		if (!arst_n) begin
			degrees_mode = 1'b0;
			angles_pending.delete();
			mismatches = 0;
		end else begin
			if (done) begin
				if (angles_pending.size() == 0) begin
					$error("result beat with no expectation waiting");
					mismatches++;
				end else begin
					exp_a = angles_pending.pop_front();
					if (latitude !== exp_a.lat) begin
						$error("latitude: expected %0d, got %0d", exp_a.lat, latitude);
						mismatches++;
					end
					if (longitude !== exp_a.lon) begin
						$error("longitude: expected %0d, got %0d", exp_a.lon, longitude);
						mismatches++;
					end
					if (zero_vector !== exp_a.zero_vec) begin
						$error("zero_vector: expected %0d, got %0d", exp_a.zero_vec,
							zero_vector);
						mismatches++;
					end
				end
			end
			if (start && !busy)
				angles_pending.push_back(predict_angles(vec_x, vec_y, vec_z, degrees_mode));
			if (psel && penable && pwrite && pready && paddr == ANGLE_CFG_BYTE_ADDR)
				degrees_mode = pwdata[0];
		end
	end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// Top of the vector_to_latitude_longitude testbench: clock, reset, command and register stimulus,
// watchdog and verdict. Depends on vtll_pkg, the block and vtll_checker.
module tb;
	import vtll_pkg::*;

	localparam int CB = 16;
	localparam int FB = 16;
	localparam int STALL_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 90;
	localparam logic [2:0] ANGLE_CFG_BYTE_ADDR = {ADDR_ANGLE_CFG, 2'b00};

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic signed [CB-1:0]  vec_x, vec_y, vec_z;
	logic                  done;
	logic signed [OW-1:0]  latitude, longitude;
	logic                  zero_vector;
	logic                  psel, penable, pwrite;
	logic [2:0]            paddr;
	logic [31:0]           pwdata, prdata;
	logic                  pready;
	int                    mismatches, outstanding;
	int                    burst_left;
	int                    idle_cycles;

	vector_to_latitude_longitude #(.COMPONENT_BITS(CB), .ANGLE_FRAC_BITS(FB)) dut (.*);

	vtll_checker #(.COMPONENT_BITS(CB), .ANGLE_FRAC_BITS(FB)) chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: the run ends when nothing moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (psel && penable))
			idle_cycles <= 0;
		else if (idle_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	task automatic wait_drained();
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Register write with a setup phase and an access phase, issued only while the pipe is empty.
	task automatic write_angle_cfg(input logic deg);
		start <= 1'b0;
		burst_left = 0;
		wait_drained();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ANGLE_CFG_BYTE_ADDR;
		pwdata <= {31'd0, deg};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// One command beat; the sender runs in bursts with random gaps between them.
	task automatic send_vector(input logic signed [CB-1:0] x, input logic signed [CB-1:0] y,
			input logic signed [CB-1:0] z);
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
		end
		burst_left--;
		start <= 1'b1;
		vec_x <= x;
		vec_y <= y;
		vec_z <= z;
		@(negedge clk);
		while (busy)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic send_directed();
		send_vector(0, 0, 0);
		send_vector(0, 1, 0);
		send_vector(0, -1, 0);
		send_vector(0, 32767, 0);
		send_vector(0, -32768, 0);
		send_vector(0, 0, -1);
		send_vector(0, 5, -32768);
		send_vector(0, 0, 32767);
		send_vector(32767, 0, 0);
		send_vector(-32768, 0, 0);
		send_vector(-32768, -32768, -32768);
		send_vector(32767, 32767, 32767);
		send_vector(-32768, 32767, -32768);
		send_vector(32767, -32768, 32767);
		send_vector(1, 0, -32768);
		send_vector(-1, 0, -32768);
		send_vector(1, 1, 1);
		send_vector(-1, -1, -1);
		send_vector(1, -32768, 0);
		send_vector(-32768, 1, 32767);
	endtask

	function automatic logic signed [CB-1:0] rand_component(input int mode);
		case (mode)
			0: return CB'($urandom);
			1: return CB'($signed($urandom_range(0, 16)) - 8);
			2: return ($urandom_range(0, 1) == 0) ? 16'sh7fff : 16'sh8000;
			default: return '0;
		endcase
	endfunction

	task automatic send_random(input int count);
		logic signed [CB-1:0] x, y, z;
		for (int n = 0; n < count; n++) begin
			x = rand_component($urandom_range(0, 5) < 3 ? 0 : $urandom_range(1, 3));
			y = rand_component($urandom_range(0, 5) < 3 ? 0 : $urandom_range(1, 3));
			z = rand_component($urandom_range(0, 5) < 3 ? 0 : $urandom_range(1, 3));
			send_vector(x, y, z);
			// With even odds, let the pipe run dry once in the middle of the stream.
			if (n == count / 2 && $urandom_range(0, 1) == 0) begin
				start <= 1'b0;
				burst_left = 0;
				wait_drained();
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		vec_x = '0;
		vec_y = '0;
		vec_z = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		burst_left = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Radians from reset, then degrees, then back to radians.
		send_directed();
		send_random(140);
		write_angle_cfg(1'b1);
		send_directed();
		send_random(140);
		write_angle_cfg(1'b0);
		send_random(130);

		start <= 1'b0;
		wait_drained();
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
